// ----- hdl/xctu_pkg.sv -----
package xctu_pkg;

    // Primary opcodes handled by the unit.
    localparam logic [7:0] OP_JCC_FIRST  = 8'h70;
    localparam logic [7:0] OP_JCC_LAST   = 8'h7F;
    localparam logic [7:0] OP_CALL_REL   = 8'hE8;
    localparam logic [7:0] OP_CALL_FAR   = 8'h9A;
    localparam logic [7:0] OP_GROUP_FF   = 8'hFF;
    localparam logic [7:0] OP_RET_NEAR   = 8'hC3;
    localparam logic [7:0] OP_RET_NEAR_N = 8'hC2;
    localparam logic [7:0] OP_RET_FAR    = 8'hCB;
    localparam logic [7:0] OP_RET_FAR_N  = 8'hCA;
    localparam logic [7:0] OP_JMP_REL16  = 8'hE9;
    localparam logic [7:0] OP_JMP_REL8   = 8'hEB;
    localparam logic [7:0] OP_JMP_FAR    = 8'hEA;
    localparam logic [7:0] OP_JCXZ       = 8'hE3;
    localparam logic [7:0] OP_LOOPNE     = 8'hE0;
    localparam logic [7:0] OP_LOOPE      = 8'hE1;
    localparam logic [7:0] OP_LOOP       = 8'hE2;
    localparam logic [7:0] OP_CLC        = 8'hF8;
    localparam logic [7:0] OP_CMC        = 8'hF5;
    localparam logic [7:0] OP_STC        = 8'hF9;
    localparam logic [7:0] OP_CLD        = 8'hFC;
    localparam logic [7:0] OP_STD        = 8'hFD;
    localparam logic [7:0] OP_CLI        = 8'hFA;
    localparam logic [7:0] OP_STI        = 8'hFB;
    localparam logic [7:0] OP_HLT        = 8'hF4;

    // ModRM reg field codes of opcode FF.
    localparam logic [2:0] SUB_CALL_NEAR = 3'd2;
    localparam logic [2:0] SUB_CALL_FAR  = 3'd3;
    localparam logic [2:0] SUB_JMP_NEAR  = 3'd4;
    localparam logic [2:0] SUB_JMP_FAR   = 3'd5;

    // Flag bit positions.
    localparam int FL_CF = 0;
    localparam int FL_PF = 2;
    localparam int FL_ZF = 6;
    localparam int FL_SF = 7;
    localparam int FL_IF = 9;
    localparam int FL_DF = 10;
    localparam int FL_OF = 11;

    // Condition groups selected by bits 3:1 of a Jcc opcode.
    localparam logic [2:0] CC_O  = 3'd0;
    localparam logic [2:0] CC_B  = 3'd1;
    localparam logic [2:0] CC_Z  = 3'd2;
    localparam logic [2:0] CC_BE = 3'd3;
    localparam logic [2:0] CC_S  = 3'd4;
    localparam logic [2:0] CC_P  = 3'd5;
    localparam logic [2:0] CC_L  = 3'd6;
    localparam logic [2:0] CC_LE = 3'd7;

    typedef struct packed {
        logic [7:0]  kind;
        logic [2:0]  sub_op;
        logic [2:0]  instr_len;
        logic [15:0] imm_first;
        logic [15:0] imm_second;
        logic [15:0] mem_first;
        logic [15:0] mem_second;
        logic [15:0] ip_now;
        logic [15:0] cs_now;
        logic [15:0] sp_now;
        logic [15:0] count_now;
        logic [15:0] flags_now;
    } xctu_req_t;

    typedef struct packed {
        logic [15:0] ip_next;
        logic [15:0] cs_next;
        logic [15:0] sp_next;
        logic [15:0] count_next;
        logic [15:0] flags_next;
        logic [1:0]  push_count;
        logic [15:0] push_word_a;
        logic [15:0] push_word_b;
        logic        taken;
        logic        halt;
        logic        bad_opcode;
    } xctu_rsp_t;

    // Evaluates the condition of a Jcc opcode against the flags word.
    function automatic logic cond_holds(input logic [3:0] cc, input logic [15:0] fl);
        logic r;
        r = 1'b0;
        unique case (cc[3:1])
            CC_O:    r = fl[FL_OF];
            CC_B:    r = fl[FL_CF];
            CC_Z:    r = fl[FL_ZF];
            CC_BE:   r = fl[FL_CF] | fl[FL_ZF];
            CC_S:    r = fl[FL_SF];
            CC_P:    r = fl[FL_PF];
            CC_L:    r = fl[FL_SF] ^ fl[FL_OF];
            CC_LE:   r = (fl[FL_SF] ^ fl[FL_OF]) | fl[FL_ZF];
            default: r = 1'b0;
        endcase
        return cc[0] ? ~r : r;
    endfunction

endpackage

// ----- hdl/xctu_if.sv -----
interface xctu_req_if;
    logic                  valid;
    logic                  ready;
    xctu_pkg::xctu_req_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface xctu_rsp_if;
    logic                  valid;
    logic                  ready;
    xctu_pkg::xctu_rsp_t   data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/x86_16_control_transfer_unit.sv -----
// Branch, call and return resolution for a 16-bit x86 core: each request carries one
// control-transfer or flag instruction with its immediates, the words already read from
// memory and the current IP, CS, SP, CX and flags, and the unit answers with the new
// register values, up to two stack words to push and the taken, halt and bad-opcode
// marks. A request is captured in an input register, resolved by one pass of
// combinational logic and captured in the result register, and a new request is
// accepted every cycle while the sink keeps taking results; the result register frees
// itself in the same cycle that its contents are taken, so the input side stalls only
// while a result is held back by the sink.
module x86_16_control_transfer_unit (
    input  logic         clk,
    input  logic         rst_n,
    xctu_req_if.sink     req,
    xctu_rsp_if.source   rsp
);

    logic                req_valid_reg;
    logic                req_valid_next;
    xctu_pkg::xctu_req_t req_data_reg;
    logic                rsp_valid_reg;
    logic                rsp_valid_next;
    xctu_pkg::xctu_rsp_t rsp_data_reg;
    xctu_pkg::xctu_rsp_t rsp_data_next;
    logic                advance;

    // The result register can take a new result when it is empty or being drained.
    assign advance   = ~rsp_valid_reg | rsp.ready;
    assign req.ready = ~req_valid_reg | advance;

    xctu_resolve u_resolve (
        .r (req_data_reg),
        .s (rsp_data_next)
    );

    always_comb
    begin
        req_valid_next = req.ready ? req.valid : req_valid_reg;
        rsp_valid_next = advance ? req_valid_reg : rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers load only when their stage takes a new request.
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_data_reg <= req.data;
        end
        if (advance && req_valid_reg)
        begin
            rsp_data_reg <= rsp_data_next;
        end
    end

    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

endmodule

// ----- hdl/xctu_resolve.sv -----
// Combinational resolution of one registered control-transfer request.
module xctu_resolve (
    input  xctu_pkg::xctu_req_t r,
    output xctu_pkg::xctu_rsp_t s
);

    logic [15:0] ret_ip;
    logic [15:0] rel8;
    logic [15:0] tgt_rel8;
    logic [15:0] tgt_rel16;
    logic [15:0] cx_dec;
    logic        loop_go;

    assign ret_ip    = r.ip_now + {13'd0, r.instr_len};
    assign rel8      = {{8{r.imm_first[7]}}, r.imm_first[7:0]};
    assign tgt_rel8  = ret_ip + rel8;
    assign tgt_rel16 = ret_ip + r.imm_first;
    assign cx_dec    = r.count_now - 16'd1;

    always_comb
    begin
        loop_go = (cx_dec != 16'd0);
        if (r.kind == xctu_pkg::OP_LOOPE)
        begin
            loop_go = loop_go & r.flags_now[xctu_pkg::FL_ZF];
        end
        else if (r.kind == xctu_pkg::OP_LOOPNE)
        begin
            loop_go = loop_go & ~r.flags_now[xctu_pkg::FL_ZF];
        end
    end

    always_comb
    begin
        s.ip_next     = r.ip_now;
        s.cs_next     = r.cs_now;
        s.sp_next     = r.sp_now;
        s.count_next  = r.count_now;
        s.flags_next  = r.flags_now;
        s.push_count  = 2'd0;
        s.push_word_a = 16'd0;
        s.push_word_b = 16'd0;
        s.taken       = 1'b0;
        s.halt        = 1'b0;
        s.bad_opcode  = 1'b0;

        unique case (r.kind) inside
            [xctu_pkg::OP_JCC_FIRST:xctu_pkg::OP_JCC_LAST]:
            begin
                if (xctu_pkg::cond_holds(r.kind[3:0], r.flags_now))
                begin
                    s.ip_next = tgt_rel8;
                    s.taken   = 1'b1;
                end
                else
                begin
                    s.ip_next = ret_ip;
                end
            end
            xctu_pkg::OP_CALL_REL:
            begin
                s.sp_next     = r.sp_now - 16'd2;
                s.push_count  = 2'd1;
                s.push_word_a = ret_ip;
                s.ip_next     = tgt_rel16;
                s.taken       = 1'b1;
            end
            xctu_pkg::OP_CALL_FAR:
            begin
                s.sp_next     = r.sp_now - 16'd4;
                s.push_count  = 2'd2;
                s.push_word_a = r.cs_now;
                s.push_word_b = ret_ip;
                s.ip_next     = r.imm_first;
                s.cs_next     = r.imm_second;
                s.taken       = 1'b1;
            end
            xctu_pkg::OP_GROUP_FF:
            begin
                unique case (r.sub_op)
                    xctu_pkg::SUB_CALL_NEAR:
                    begin
                        s.sp_next     = r.sp_now - 16'd2;
                        s.push_count  = 2'd1;
                        s.push_word_a = ret_ip;
                        s.ip_next     = r.mem_first;
                        s.taken       = 1'b1;
                    end
                    xctu_pkg::SUB_CALL_FAR:
                    begin
                        s.sp_next     = r.sp_now - 16'd4;
                        s.push_count  = 2'd2;
                        s.push_word_a = r.cs_now;
                        s.push_word_b = ret_ip;
                        s.ip_next     = r.mem_first;
                        s.cs_next     = r.mem_second;
                        s.taken       = 1'b1;
                    end
                    xctu_pkg::SUB_JMP_NEAR:
                    begin
                        s.ip_next = r.mem_first;
                        s.taken   = 1'b1;
                    end
                    xctu_pkg::SUB_JMP_FAR:
                    begin
                        s.ip_next = r.mem_first;
                        s.cs_next = r.mem_second;
                        s.taken   = 1'b1;
                    end
                    default:
                    begin
                        s.bad_opcode = 1'b1;
                    end
                endcase
            end
            xctu_pkg::OP_RET_NEAR:
            begin
                s.ip_next = r.mem_first;
                s.sp_next = r.sp_now + 16'd2;
                s.taken   = 1'b1;
            end
            xctu_pkg::OP_RET_NEAR_N:
            begin
                s.ip_next = r.mem_first;
                s.sp_next = r.sp_now + 16'd2 + r.imm_first;
                s.taken   = 1'b1;
            end
            xctu_pkg::OP_RET_FAR:
            begin
                s.ip_next = r.mem_first;
                s.cs_next = r.mem_second;
                s.sp_next = r.sp_now + 16'd4;
                s.taken   = 1'b1;
            end
            xctu_pkg::OP_RET_FAR_N:
            begin
                s.ip_next = r.mem_first;
                s.cs_next = r.mem_second;
                s.sp_next = r.sp_now + 16'd4 + r.imm_first;
                s.taken   = 1'b1;
            end
            xctu_pkg::OP_JMP_REL16:
            begin
                s.ip_next = tgt_rel16;
                s.taken   = 1'b1;
            end
            xctu_pkg::OP_JMP_REL8:
            begin
                s.ip_next = tgt_rel8;
                s.taken   = 1'b1;
            end
            xctu_pkg::OP_JMP_FAR:
            begin
                s.ip_next = r.imm_first;
                s.cs_next = r.imm_second;
                s.taken   = 1'b1;
            end
            xctu_pkg::OP_JCXZ:
            begin
                if (r.count_now == 16'd0)
                begin
                    s.ip_next = tgt_rel8;
                    s.taken   = 1'b1;
                end
                else
                begin
                    s.ip_next = ret_ip;
                end
            end
            xctu_pkg::OP_LOOPNE, xctu_pkg::OP_LOOPE, xctu_pkg::OP_LOOP:
            begin
                s.count_next = cx_dec;
                if (loop_go)
                begin
                    s.ip_next = tgt_rel8;
                    s.taken   = 1'b1;
                end
                else
                begin
                    s.ip_next = ret_ip;
                end
            end
            xctu_pkg::OP_CLC:
            begin
                s.flags_next[xctu_pkg::FL_CF] = 1'b0;
                s.ip_next = ret_ip;
            end
            xctu_pkg::OP_CMC:
            begin
                s.flags_next[xctu_pkg::FL_CF] = ~r.flags_now[xctu_pkg::FL_CF];
                s.ip_next = ret_ip;
            end
            xctu_pkg::OP_STC:
            begin
                s.flags_next[xctu_pkg::FL_CF] = 1'b1;
                s.ip_next = ret_ip;
            end
            xctu_pkg::OP_CLD:
            begin
                s.flags_next[xctu_pkg::FL_DF] = 1'b0;
                s.ip_next = ret_ip;
            end
            xctu_pkg::OP_STD:
            begin
                s.flags_next[xctu_pkg::FL_DF] = 1'b1;
                s.ip_next = ret_ip;
            end
            xctu_pkg::OP_CLI:
            begin
                s.flags_next[xctu_pkg::FL_IF] = 1'b0;
                s.ip_next = ret_ip;
            end
            xctu_pkg::OP_STI:
            begin
                s.flags_next[xctu_pkg::FL_IF] = 1'b1;
                s.ip_next = ret_ip;
            end
            xctu_pkg::OP_HLT:
            begin
                s.halt    = 1'b1;
                s.ip_next = ret_ip;
            end
            default:
            begin
                s.bad_opcode = 1'b1;
            end
        endcase
    end

endmodule
